@@ sv/barometric_pressure_compensation_unit_assert.svh @@
// assertion macros shared by the checker of the pressure compensation unit
// depends on nothing; included by the checker file only
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define BPC_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BPC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bpc_pkg.sv @@
// types, constants and register indexes of the pressure compensation unit
// depends on nothing; imported by every module of the block except bpc_queue
package bpc_pkg;

    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 32;
    localparam int DT_W    = 25;

    localparam int BPC_MID_DEPTH = 4;
    localparam int BPC_OUT_DEPTH = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEF = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEF      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_COEF      = CFG_IDX_W'(5);

    // 20.00 and -15.00 degrees in hundredths
    localparam logic signed [TEMP_W-1:0] TEMP_REF_CENTI = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_CENTI = -19'sd1500;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } conversion_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_centi;
        logic signed [PRES_W-1:0] pressure_value;
    } result_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coef;
        logic [CAL_W-1:0] offset_temp_coef;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_coef;
    } cal_t;

    // item as it leaves the front end: raw pressure and temperature delta
    typedef struct packed {
        logic [RAW_W-1:0]       d1;
        logic signed [DT_W-1:0] dt;
    } prep_t;

endpackage

@@ sv/bpc_queue.sv @@
// small first-in first-out queue built from a register array
// depends on nothing; used between front and back end and at the result side
module bpc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/bpc_front.sv @@
// front end: takes conversions, forms the temperature delta, feeds the queue
// depends on bpc_pkg
module bpc_front
    import bpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  conversion_t      conversion,
    input  logic [CAL_W-1:0] reference_temperature,
    input  logic             q_full,
    output logic             q_push,
    output prep_t            q_data
);

    logic  valid_reg, valid_next;
    prep_t stage_reg;
    prep_t stage_next;
    logic  accept;

    // the stage holds only while the queue is full
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_data = stage_reg;

    always_comb
    begin
        stage_next.d1 = conversion.raw_pressure;
        stage_next.dt = $signed({1'b0, conversion.raw_temperature}
                                - {1'b0, reference_temperature, 8'd0});
        valid_next    = accept || (valid_reg && q_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ sv/bpc_back.sv @@
// back end: eight-stage compensation pipeline with credit toward the result queue
// depends on bpc_pkg
module bpc_back
    import bpc_pkg::*;
#(
    parameter int OUT_DEPTH = BPC_OUT_DEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cal_t    cal,
    input  logic    mid_empty,
    input  prep_t   mid_data,
    output logic    mid_pop,
    input  logic    out_pop,
    output logic    out_push,
    output result_t out_data
);

    localparam int CRED_W = $clog2(OUT_DEPTH + 1);
    localparam int STAGES = 8;

    logic [CRED_W-1:0] credit_reg, credit_next;
    logic [STAGES-1:0] valid_reg, valid_next;
    logic              issue;

    // stage 1: issued item
    logic [RAW_W-1:0]       d1_1_reg;
    logic signed [DT_W-1:0] dt_1_reg;
    // stage 2: first products
    logic [RAW_W-1:0]       d1_2_reg;
    logic signed [41:0]     mt_2_reg, mt_next;
    logic signed [41:0]     mo_2_reg, mo_next;
    logic signed [41:0]     ms_2_reg, ms_next;
    logic signed [49:0]     mdd_2_reg, mdd_next;
    // stage 3: first-order terms
    logic [RAW_W-1:0]         d1_3_reg;
    logic signed [TEMP_W-1:0] temp_3_reg, temp_3_next;
    logic signed [39:0]       off_3_reg, off_3_next;
    logic signed [39:0]       sens_3_reg, sens_3_next;
    logic [16:0]              t2_3_reg;
    // stage 4: squares and region flags
    logic [RAW_W-1:0]         d1_4_reg;
    logic signed [TEMP_W-1:0] temp_4_reg;
    logic signed [39:0]       off_4_reg, sens_4_reg;
    logic [16:0]              t2_4_reg;
    logic                     lo_4_reg, vlo_4_reg;
    logic signed [39:0]       sqa_4_reg, sqa_next;
    logic signed [39:0]       sqb_4_reg, sqb_next;
    logic signed [19:0]       a_c, b_c;
    // stage 5: second-order corrections
    logic [RAW_W-1:0]         d1_5_reg;
    logic signed [TEMP_W-1:0] temp_5_reg;
    logic signed [39:0]       off_5_reg, sens_5_reg;
    logic [16:0]              t2_5_reg;
    logic                     lo_5_reg;
    logic [43:0]              off2_5_reg, off2_next;
    logic [43:0]              sens2_5_reg, sens2_next;
    logic [43:0]              sa, sb, a5, b7, b11, off2_base, sens2_base;
    // stage 6: corrected terms
    logic [RAW_W-1:0]         d1_6_reg;
    logic signed [TEMP_W-1:0] temp_6_reg, temp_6_next;
    logic signed [39:0]       off_6_reg, off_6_next;
    logic signed [39:0]       sens_6_reg, sens_6_next;
    logic [44:0]              off_diff, sens_diff;
    // stage 7: partial products of d1 * sens
    logic signed [TEMP_W-1:0] temp_7_reg;
    logic signed [39:0]       off_7_reg;
    logic [43:0]              plo_7_reg, plo_next;
    logic signed [44:0]       phi_7_reg, phi_next;
    // stage 8: scaled product
    logic signed [TEMP_W-1:0] temp_8_reg;
    logic signed [39:0]       off_8_reg;
    logic [43:0]              q_8_reg;
    logic [64:0]              prod;
    logic [45:0]              r_h;

    // credit covers items in flight plus items waiting in the result queue
    assign issue   = !mid_empty && (credit_reg < CRED_W'(OUT_DEPTH));
    assign mid_pop = issue;

    always_comb
    begin
        credit_next = credit_reg;
        if (issue && !out_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (out_pop && !issue)
        begin
            credit_next = credit_reg - 1'b1;
        end
        valid_next = {valid_reg[STAGES-2:0], issue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            valid_reg  <= valid_next;
        end
    end

    always_comb
    begin
        mt_next  = dt_1_reg * $signed({1'b0, cal.temperature_coef});
        mo_next  = dt_1_reg * $signed({1'b0, cal.offset_temp_coef});
        ms_next  = dt_1_reg * $signed({1'b0, cal.sensitivity_temp_coef});
        mdd_next = dt_1_reg * dt_1_reg;
    end

    always_comb
    begin
        temp_3_next = $signed(mt_2_reg[41:23]) + TEMP_REF_CENTI;
        off_3_next  = $signed({8'd0, cal.pressure_offset, 16'd0}
                              + {{5{mo_2_reg[41]}}, mo_2_reg[41:7]});
        sens_3_next = $signed({9'd0, cal.pressure_sensitivity, 15'd0}
                              + {{6{ms_2_reg[41]}}, ms_2_reg[41:8]});
    end

    always_comb
    begin
        a_c      = $signed({temp_3_reg[TEMP_W-1], temp_3_reg}) - 20'sd2000;
        b_c      = $signed({temp_3_reg[TEMP_W-1], temp_3_reg}) + 20'sd1500;
        sqa_next = a_c * a_c;
        sqb_next = b_c * b_c;
    end

    // squares are never negative, so the halvings are plain shifts
    always_comb
    begin
        sa         = {4'd0, sqa_4_reg};
        sb         = {4'd0, sqb_4_reg};
        a5         = (sa << 2) + sa;
        b7         = (sb << 3) - sb;
        b11        = (sb << 3) + (sb << 1) + sb;
        off2_base  = a5 >> 1;
        sens2_base = off2_base >> 1;
        off2_next  = vlo_4_reg ? off2_base + b7 : off2_base;
        sens2_next = vlo_4_reg ? sens2_base + (b11 >> 1) : sens2_base;
    end

    always_comb
    begin
        off_diff    = {{5{off_5_reg[39]}}, off_5_reg} - {1'b0, off2_5_reg};
        sens_diff   = {{5{sens_5_reg[39]}}, sens_5_reg} - {1'b0, sens2_5_reg};
        temp_6_next = lo_5_reg ? temp_5_reg - $signed({2'b00, t2_5_reg}) : temp_5_reg;
        off_6_next  = lo_5_reg ? $signed(off_diff[39:0]) : off_5_reg;
        sens_6_next = lo_5_reg ? $signed(sens_diff[39:0]) : sens_5_reg;
    end

    always_comb
    begin
        plo_next = d1_6_reg * sens_6_reg[19:0];
        phi_next = $signed({1'b0, d1_6_reg}) * $signed(sens_6_reg[39:20]);
    end

    always_comb
    begin
        prod = {phi_7_reg, 20'd0} + {21'd0, plo_7_reg};
    end

    // result magnitude stays far inside 32 bits, the clamp is a sign extension
    always_comb
    begin
        r_h = {{2{q_8_reg[43]}}, q_8_reg} - {{6{off_8_reg[39]}}, off_8_reg};
        out_push                   = valid_reg[STAGES-1];
        out_data.temperature_centi = temp_8_reg;
        out_data.pressure_value    = $signed({r_h[45], r_h[45:15]});
    end

    always_ff @(posedge clk)
    begin
        d1_1_reg    <= mid_data.d1;
        dt_1_reg    <= mid_data.dt;

        d1_2_reg    <= d1_1_reg;
        mt_2_reg    <= mt_next;
        mo_2_reg    <= mo_next;
        ms_2_reg    <= ms_next;
        mdd_2_reg   <= mdd_next;

        d1_3_reg    <= d1_2_reg;
        temp_3_reg  <= temp_3_next;
        off_3_reg   <= off_3_next;
        sens_3_reg  <= sens_3_next;
        t2_3_reg    <= mdd_2_reg[47:31];

        d1_4_reg    <= d1_3_reg;
        temp_4_reg  <= temp_3_reg;
        off_4_reg   <= off_3_reg;
        sens_4_reg  <= sens_3_reg;
        t2_4_reg    <= t2_3_reg;
        lo_4_reg    <= temp_3_reg < TEMP_REF_CENTI;
        vlo_4_reg   <= temp_3_reg < TEMP_LOW_CENTI;
        sqa_4_reg   <= sqa_next;
        sqb_4_reg   <= sqb_next;

        d1_5_reg    <= d1_4_reg;
        temp_5_reg  <= temp_4_reg;
        off_5_reg   <= off_4_reg;
        sens_5_reg  <= sens_4_reg;
        t2_5_reg    <= t2_4_reg;
        lo_5_reg    <= lo_4_reg;
        off2_5_reg  <= off2_next;
        sens2_5_reg <= sens2_next;

        d1_6_reg    <= d1_5_reg;
        temp_6_reg  <= temp_6_next;
        off_6_reg   <= off_6_next;
        sens_6_reg  <= sens_6_next;

        temp_7_reg  <= temp_6_reg;
        off_7_reg   <= off_6_reg;
        plo_7_reg   <= plo_next;
        phi_7_reg   <= phi_next;

        temp_8_reg  <= temp_7_reg;
        off_8_reg   <= off_7_reg;
        q_8_reg     <= prod[64:21];
    end

endmodule

@@ sv/barometric_pressure_compensation_unit.sv @@
// top level of the barometric pressure compensation unit
// depends on bpc_pkg, bpc_front, bpc_queue and bpc_back
//
// usage:
//   conversions enter through push/full: a transaction completes when push is
//   high and full is low; one raw pressure and one raw temperature word each
//   results leave through empty/pop: the oldest result sits on result while
//   empty is low and a transaction completes when pop is high and empty is low
//   calibration words are written over cfg_valid/cfg_ready (ready is always
//   high), cfg_index selecting the word; indexes past the list are ignored
// a result reaches the ports through the input stage, the middle queue, eight
//   pipeline stages and the result queue
// throughput: one conversion per cycle while full is low, set by the fully
//   pipelined back end, in which each bank of multipliers has its own stage
// reset empties all queues, clears the valid bits and sets the calibration words to zero
// when the receiver stalls, the result queue fills up to OUT_DEPTH entries,
//   the back end stops issuing, the middle queue fills and full goes high;
//   nothing is dropped
module barometric_pressure_compensation_unit
    import bpc_pkg::*;
#(
    parameter int MID_DEPTH = BPC_MID_DEPTH,
    parameter int OUT_DEPTH = BPC_OUT_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  conversion_t          conversion,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data
);

    localparam int PREP_W = $bits(prep_t);
    localparam int RES_W  = $bits(result_t);

    cal_t             cal_reg, cal_next;
    logic             mid_full, mid_push, mid_empty, mid_pop;
    prep_t            mid_wdata, mid_rdata;
    logic [PREP_W-1:0] mid_rbits;
    logic             out_push;
    result_t          out_wdata;
    logic [RES_W-1:0] out_rbits;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PRESSURE_SENSITIVITY:  cal_next.pressure_sensitivity  = cfg_data;
                REG_PRESSURE_OFFSET:       cal_next.pressure_offset       = cfg_data;
                REG_SENSITIVITY_TEMP_COEF: cal_next.sensitivity_temp_coef = cfg_data;
                REG_OFFSET_TEMP_COEF:      cal_next.offset_temp_coef      = cfg_data;
                REG_REFERENCE_TEMPERATURE: cal_next.reference_temperature = cfg_data;
                REG_TEMPERATURE_COEF:      cal_next.temperature_coef      = cfg_data;
                default:                   cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    bpc_front u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .push                  (push),
        .full                  (full),
        .conversion            (conversion),
        .reference_temperature (cal_reg.reference_temperature),
        .q_full                (mid_full),
        .q_push                (mid_push),
        .q_data                (mid_wdata)
    );

    bpc_queue #(
        .WIDTH (PREP_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rbits),
        .empty (mid_empty)
    );

    assign mid_rdata = prep_t'(mid_rbits);

    bpc_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .mid_empty (mid_empty),
        .mid_data  (mid_rdata),
        .mid_pop   (mid_pop),
        .out_pop   (pop && !empty),
        .out_push  (out_push),
        .out_data  (out_wdata)
    );

    bpc_queue #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (),
        .pop   (pop),
        .rdata (out_rbits),
        .empty (empty)
    );

    assign result = result_t'(out_rbits);

endmodule

@@ sv/bpc_checker.sv @@
// port-level checker of the pressure compensation unit, bound to the top level
// depends on bpc_pkg and barometric_pressure_compensation_unit_assert.svh
`include "barometric_pressure_compensation_unit_assert.svh"

module bpc_port_checker
    import bpc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    push,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input result_t result,
    input logic    cfg_valid,
    input logic    cfg_ready
);

    localparam int PEND_W = 16;

    logic [PEND_W-1:0] pending_reg, pending_next;
    logic              in_txn, out_txn;

    assign in_txn  = push && !full;
    assign out_txn = pop && !empty;

    // items taken in whose results have not yet been taken out
    always_comb
    begin
        pending_next = pending_reg;
        if (in_txn && !out_txn)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_txn && !in_txn)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `BPC_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(result), "result changed while stalled")
    `BPC_ASSERT_IMP(a_no_phantom_result, clk, rst_n, pending_reg == '0, empty, "result without a pending transaction")
    `BPC_ASSERT_NEXT(a_no_bypass, clk, rst_n, in_txn && pending_reg == '0, empty, "result appeared one cycle after input")
    `BPC_ASSERT_IMP(a_cfg_always_ready, clk, rst_n, cfg_valid, cfg_ready, "configuration write not taken")

endmodule

bind barometric_pressure_compensation_unit bpc_port_checker u_bpc_checker (.*);
